// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the packed media ALU.
// Define NO_ASSERTIONS to build without them; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Property that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, prop)
`endif
`endif

// ----- src/pma_pkg.sv -----
// Package for the packed media ALU: opcodes, opcode field bits and stage types.
// No dependencies.
`timescale 1ns / 1ps

package pma_pkg;

   // Opcodes
   localparam logic [3:0] OP_MINUB8 = 4'd0;
   localparam logic [3:0] OP_MINSB8 = 4'd1;
   localparam logic [3:0] OP_MINUW4 = 4'd2;
   localparam logic [3:0] OP_MINSW4 = 4'd3;
   localparam logic [3:0] OP_MAXUB8 = 4'd4;
   localparam logic [3:0] OP_MAXSB8 = 4'd5;
   localparam logic [3:0] OP_MAXUW4 = 4'd6;
   localparam logic [3:0] OP_MAXSW4 = 4'd7;
   localparam logic [3:0] OP_PERR   = 4'd8;
   localparam logic [3:0] OP_PKLB   = 4'd9;
   localparam logic [3:0] OP_PKWB   = 4'd10;
   localparam logic [3:0] OP_UNPKBL = 4'd11;
   localparam logic [3:0] OP_UNPKBW = 4'd12;

   // Field bits of the min/max opcodes
   localparam int OPB_SIGNED = 0;
   localparam int OPB_WORD   = 1;
   localparam int OPB_MAX    = 2;
   localparam int OPB_GROUP  = 3;

   // Bits of the pixel error sum (at most 2040)
   localparam int PERR_W = 11;

   // First stage: operands plus lane compare and difference results
   typedef struct packed {
      logic [3:0]       op;
      logic [63:0]      a;
      logic [63:0]      b;
      logic [63:0]      braw;
      logic [7:0]       sel8;
      logic [3:0]       sel16;
      logic [7:0][7:0]  ad;
   } s1_type;

   // Second stage: lane result and pixel error partial sums
   typedef struct packed {
      logic             is_perr;
      logic [63:0]      word;
      logic [1:0][9:0]  psum;
   } s2_type;

endpackage

// ----- src/packed_media_alu_unit.sv -----
// Packed media ALU: lane min/max, pixel error, pack and unpack.
// Three register stages (compare, select/add, sum) lie between an accepted request
// and its rsp_valid strobe; one request per cycle is taken outside reset.
// busy is high only during reset; synchronous reset clears the stage valid bits.
// Results cannot be held off by the receiver; each is shown for one cycle.
// Depends on pma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_media_alu_unit
   import pma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_op,
   input  logic [63:0] req_src_a,
   input  logic [63:0] req_src_b,
   input  logic        req_use_literal,
   input  logic [7:0]  req_literal_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_result
);

   logic          accept;
   logic [63:0]   b_sel;
   logic          sgn;
   logic          take_max;
   logic [7:0][7:0]   ka8;
   logic [7:0][7:0]   kb8;
   logic [3:0][15:0]  ka16;
   logic [3:0][15:0]  kb16;

   s1_type        s1_in;
   s1_type        s1_ff;
   logic          s1_valid_ff;
   s2_type        s2_in;
   s2_type        s2_ff;
   logic          s2_valid_ff;
   logic          rsp_valid_ff;
   logic [63:0]   rsp_result_in;
   logic [63:0]   rsp_result_ff;
   logic [PERR_W-1:0] perr_sum;

   // Handshake: the pipeline never stalls
   assign busy   = reset;
   assign accept = start & ~busy;

   // Stage 1: operand select, lane keys, compares and byte differences
   assign b_sel    = req_use_literal ? {56'd0, req_literal_value} : req_src_b;
   assign sgn      = req_op[OPB_SIGNED];
   assign take_max = req_op[OPB_MAX];

   always_comb begin
      s1_in.op   = req_op;
      s1_in.a    = req_src_a;
      s1_in.b    = b_sel;
      s1_in.braw = req_src_b;
      for (int i = 0; i < 8; i++) begin
         ka8[i] = {req_src_a[8*i+7] ^ sgn, req_src_a[8*i +: 7]};
         kb8[i] = {b_sel[8*i+7] ^ sgn, b_sel[8*i +: 7]};
         s1_in.sel8[i] = take_max ? (ka8[i] > kb8[i]) : (ka8[i] < kb8[i]);
         s1_in.ad[i]   = (req_src_a[8*i +: 8] > b_sel[8*i +: 8]) ?
                         (req_src_a[8*i +: 8] - b_sel[8*i +: 8]) :
                         (b_sel[8*i +: 8] - req_src_a[8*i +: 8]);
      end
      for (int i = 0; i < 4; i++) begin
         ka16[i] = {req_src_a[16*i+15] ^ sgn, req_src_a[16*i +: 15]};
         kb16[i] = {b_sel[16*i+15] ^ sgn, b_sel[16*i +: 15]};
         s1_in.sel16[i] = take_max ? (ka16[i] > kb16[i]) : (ka16[i] < kb16[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_ff <= s1_in;
   end

   // Stage 2: lane selection, pack/unpack, first pixel error adds
   always_comb begin
      s2_in.is_perr = (s1_ff.op == OP_PERR);
      s2_in.word    = 64'd0;
      unique case (s1_ff.op)
         OP_MINUB8, OP_MINSB8, OP_MAXUB8, OP_MAXSB8: begin
            for (int i = 0; i < 8; i++) begin
               s2_in.word[8*i +: 8] = s1_ff.sel8[i] ? s1_ff.a[8*i +: 8] : s1_ff.b[8*i +: 8];
            end
         end
         OP_MINUW4, OP_MINSW4, OP_MAXUW4, OP_MAXSW4: begin
            for (int i = 0; i < 4; i++) begin
               s2_in.word[16*i +: 16] = s1_ff.sel16[i] ? s1_ff.a[16*i +: 16] :
                                                         s1_ff.b[16*i +: 16];
            end
         end
         OP_PKLB: begin
            s2_in.word[7:0]   = s1_ff.braw[7:0];
            s2_in.word[15:8]  = s1_ff.braw[39:32];
         end
         OP_PKWB: begin
            s2_in.word[7:0]   = s1_ff.braw[7:0];
            s2_in.word[15:8]  = s1_ff.braw[23:16];
            s2_in.word[23:16] = s1_ff.braw[39:32];
            s2_in.word[31:24] = s1_ff.braw[55:48];
         end
         OP_UNPKBL: begin
            s2_in.word[7:0]   = s1_ff.braw[7:0];
            s2_in.word[39:32] = s1_ff.braw[15:8];
         end
         OP_UNPKBW: begin
            s2_in.word[7:0]   = s1_ff.braw[7:0];
            s2_in.word[23:16] = s1_ff.braw[15:8];
            s2_in.word[39:32] = s1_ff.braw[23:16];
            s2_in.word[55:48] = s1_ff.braw[31:24];
         end
         default: begin
            s2_in.word = 64'd0;   // pixel error and undefined codes
         end
      endcase
      // two levels of the difference adder tree
      for (int j = 0; j < 2; j++) begin
         s2_in.psum[j] = ({2'b00, s1_ff.ad[4*j]}   + {2'b00, s1_ff.ad[4*j+1]})
                       + ({2'b00, s1_ff.ad[4*j+2]} + {2'b00, s1_ff.ad[4*j+3]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ff <= s2_in;
   end

   // Stage 3: final pixel error add and result select
   assign perr_sum      = {1'b0, s2_ff.psum[0]} + {1'b0, s2_ff.psum[1]};
   assign rsp_result_in = s2_ff.is_perr ? {{(64-PERR_W){1'b0}}, perr_sum} : s2_ff.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // Checks
   `ASSERT_IMPLIES(a_latency, clock, reset, accept, ##3 rsp_valid)
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_valid, $past(accept, 3))
   `ASSERT_IMPLIES(a_perr_range, clock, reset,
      rsp_valid && $past(req_op == OP_PERR, 3), rsp_result[63:PERR_W] == '0)
   `ASSERT_IMPLIES(a_pack_high_zero, clock, reset,
      rsp_valid && ($past(req_op == OP_PKLB, 3) || $past(req_op == OP_PKWB, 3)),
      rsp_result[63:32] == '0)

endmodule

// ----- test/packed_media_alu_checker.sv -----
// Result checker for the packed media ALU: predicts each destination word from the
// accepted request and compares it with the rsp_ strobe. Depends on pma_pkg.
`timescale 1ns / 1ps

module packed_media_alu_checker
   import pma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_op,
   input  logic [63:0] req_src_a,
   input  logic [63:0] req_src_b,
   input  logic        req_use_literal,
   input  logic [7:0]  req_literal_value,
   input  logic        rsp_valid,
   input  logic [63:0] rsp_result,
   output int          mismatches,
   output int          dest_pending
);

   // destination words still owed by the unit, oldest first
   logic [63:0] dest_due [$];
   int          lines_shown;

   initial begin
      mismatches   = 0;
      dest_pending = 0;
      lines_shown  = 0;
   end

   // per-lane min/max over byte or word lanes; signed order by flipping the lane's top bit
   function automatic logic [63:0] lane_minmax(input logic [63:0] a, input logic [63:0] b,
                                               input bit wide, input bit sgn,
                                               input bit take_max);
      logic [63:0] r;
      logic [15:0] x, y, kx, ky, pick, flip;
      int          w, n, i;
      r    = '0;
      w    = wide ? 16 : 8;
      n    = 64 / w;
      flip = sgn ? (wide ? 16'h8000 : 16'h0080) : 16'h0000;
      for (i = 0; i < n; i++) begin
         x    = wide ? a[i*16 +: 16] : {8'h00, a[i*8 +: 8]};
         y    = wide ? b[i*16 +: 16] : {8'h00, b[i*8 +: 8]};
         kx   = x ^ flip;
         ky   = y ^ flip;
         if (take_max) pick = (kx > ky) ? x : y;
         else          pick = (kx < ky) ? x : y;
         r    = r | ({48'h0, pick} << (i * w));
      end
      return r;
   endfunction

   // sum of absolute byte differences, at most 2040
   function automatic logic [63:0] pixel_error_sum(input logic [63:0] a,
                                                   input logic [63:0] b);
      int sum, x, y, k;
      sum = 0;
      for (k = 0; k < 8; k++) begin
         x   = int'(a[k*8 +: 8]);
         y   = int'(b[k*8 +: 8]);
         sum = sum + ((x > y) ? (x - y) : (y - x));
      end
      return 64'(sum);
   endfunction

   // expected destination word for one request
   function automatic logic [63:0] predict_dest(input logic [3:0] op, input logic [63:0] a,
                                                input logic [63:0] braw, input logic ul,
                                                input logic [7:0] lit);
      logic [63:0] b;
      b = ul ? {56'h0, lit} : braw;
      if (!op[OPB_GROUP])
         return lane_minmax(a, b, op[OPB_WORD], op[OPB_SIGNED], op[OPB_MAX]);
      case (op)
         OP_PERR:   return pixel_error_sum(a, b);
         // pack and unpack always take the register operand
         OP_PKLB:   return {48'h0, braw[39:32], braw[7:0]};
         OP_PKWB:   return {32'h0, braw[55:48], braw[39:32], braw[23:16], braw[7:0]};
         OP_UNPKBL: return {24'h0, braw[15:8], 24'h0, braw[7:0]};
         OP_UNPKBW: return {8'h0, braw[31:24], 8'h0, braw[23:16],
                            8'h0, braw[15:8], 8'h0, braw[7:0]};
         default:   return '0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (lines_shown < 100)
         $display("mismatch at %0t ns: %s", $time, msg);
      lines_shown = lines_shown + 1;
      mismatches  = mismatches + 1;
   endtask

   // compare results first, then record the request taken at this edge
   always @(posedge clock) begin : watch
      logic [63:0] want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            report_mismatch("rsp_valid unknown");
         end else if (rsp_valid) begin
            if (dest_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_result));
            end else begin
               want = dest_due.pop_front();
               if (rsp_result !== want)
                  report_mismatch($sformatf("result %h, want %h", rsp_result, want));
            end
         end
         if (start && !busy)
            dest_due.push_back(predict_dest(req_op, req_src_a, req_src_b,
                                            req_use_literal, req_literal_value));
      end
      dest_pending <= dest_due.size();
   end

endmodule

// ----- test/tb_packed_media_alu_unit.sv -----
// Testbench top for packed_media_alu_unit: clock, reset, directed and random requests
// in bursts, and the verdict. Depends on pma_pkg and packed_media_alu_checker.
`timescale 1ns / 1ps

module tb_packed_media_alu_unit
   import pma_pkg::*;
;

   localparam int RANDOM_REQUESTS = 1950;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int SETTLE_CYCLES   = 10;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic [3:0]  req_op            = OP_MINUB8;
   logic [63:0] req_src_a         = '0;
   logic [63:0] req_src_b         = '0;
   logic        req_use_literal   = 1'b0;
   logic [7:0]  req_literal_value = '0;
   logic        busy;
   logic        rsp_valid;
   logic [63:0] rsp_result;
   int          mismatches;
   int          dest_pending;
   int          cycle_count = 0;

   packed_media_alu_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_src_a         (req_src_a),
      .req_src_b         (req_src_b),
      .req_use_literal   (req_use_literal),
      .req_literal_value (req_literal_value),
      .rsp_valid         (rsp_valid),
      .rsp_result        (rsp_result)
   );

   packed_media_alu_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_src_a         (req_src_a),
      .req_src_b         (req_src_b),
      .req_use_literal   (req_use_literal),
      .req_literal_value (req_literal_value),
      .rsp_valid         (rsp_valid),
      .rsp_result        (rsp_result),
      .mismatches        (mismatches),
      .dest_pending      (dest_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // present one request and hold it until taken
   task automatic send_request(input logic [3:0] op, input logic [63:0] a,
                               input logic [63:0] b, input logic ul, input logic [7:0] lit);
      start             <= 1'b1;
      req_op            <= op;
      req_src_a         <= a;
      req_src_b         <= b;
      req_use_literal   <= ul;
      req_literal_value <= lit;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every result owed has come back, with a bound
   task automatic wait_drained();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (dest_pending != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // bytes biased to the sign and range boundaries
   function automatic logic [63:0] boundary_word();
      logic [63:0] w;
      int          k;
      for (k = 0; k < 8; k++) begin
         case ($urandom_range(5))
            0:       w[k*8 +: 8] = 8'h00;
            1:       w[k*8 +: 8] = 8'h7F;
            2:       w[k*8 +: 8] = 8'h80;
            3:       w[k*8 +: 8] = 8'hFF;
            default: w[k*8 +: 8] = 8'($urandom);
         endcase
      end
      return w;
   endfunction

   // operand B close to A: equal, off by one, or unrelated per byte
   function automatic logic [63:0] near_word(input logic [63:0] a);
      logic [63:0] w;
      int          k;
      for (k = 0; k < 8; k++) begin
         case ($urandom_range(3))
            0:       w[k*8 +: 8] = a[k*8 +: 8];
            1:       w[k*8 +: 8] = a[k*8 +: 8] + 8'd1;
            2:       w[k*8 +: 8] = a[k*8 +: 8] - 8'd1;
            default: w[k*8 +: 8] = 8'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic send_random_request();
      logic [3:0]  op;
      logic [63:0] a, b;
      logic        ul;
      op = 4'($urandom_range(int'(OP_UNPKBW)));
      case ($urandom_range(2))
         0: begin a = random_word();   b = random_word();   end
         1: begin a = boundary_word(); b = boundary_word(); end
         default: begin a = random_word(); b = near_word(a); end
      endcase
      ul = ($urandom_range(3) == 0);
      send_request(op, a, b, ul, 8'($urandom));
   endtask

   initial begin : stimulus
      int sent, burst, k;
      logic [63:0] mix_a, mix_b, ramp;
      mix_a = 64'h7F80_FF00_017F_80FE;
      mix_b = 64'h807F_00FF_7F01_FE80;
      ramp  = 64'h0123_4567_89AB_CDEF;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: each min/max flavour on sign-boundary lanes
      send_request(OP_MINUB8, mix_a, mix_b, 1'b0, 8'h00);
      send_request(OP_MINSB8, mix_a, mix_b, 1'b0, 8'h00);
      send_request(OP_MAXUB8, mix_a, mix_b, 1'b0, 8'h00);
      send_request(OP_MAXSB8, mix_a, mix_b, 1'b0, 8'h00);
      send_request(OP_MINUW4, 64'h0000_FFFF_8000_7FFF, 64'hFFFF_0000_7FFF_8000, 1'b0, 8'h00);
      send_request(OP_MINSW4, 64'h0000_FFFF_8000_7FFF, 64'hFFFF_0000_7FFF_8000, 1'b0, 8'h00);
      send_request(OP_MAXUW4, 64'h0000_FFFF_8000_7FFF, 64'hFFFF_0000_7FFF_8000, 1'b0, 8'h00);
      send_request(OP_MAXSW4, 64'h0000_FFFF_8000_7FFF, 64'hFFFF_0000_7FFF_8000, 1'b0, 8'h00);
      // extremes and equal lanes
      send_request(OP_MINUB8, 64'h0, '1, 1'b0, 8'h00);
      send_request(OP_MAXSW4, ramp, ramp, 1'b0, 8'h00);
      // literal replaces B for min/max
      send_request(OP_MINUB8, '1, '1, 1'b1, 8'hFF);
      send_request(OP_MAXSB8, mix_a, '1, 1'b1, 8'h80);
      send_request(OP_MINSW4, mix_a, '0, 1'b1, 8'h80);
      send_request(OP_MAXUW4, 64'h0, '1, 1'b1, 8'h01);
      // pixel error: largest sum, zero sum, literal
      send_request(OP_PERR, 64'h0, '1, 1'b0, 8'h00);
      send_request(OP_PERR, '1, '1, 1'b1, 8'h00);
      send_request(OP_PERR, ramp, ramp, 1'b0, 8'h00);
      send_request(OP_PERR, mix_a, ramp, 1'b1, 8'hFF);
      // pack and unpack ignore A and the literal
      send_request(OP_PKLB, '1, ramp, 1'b1, 8'h5A);
      send_request(OP_PKWB, '1, ramp, 1'b0, 8'h00);
      send_request(OP_UNPKBL, ramp, ramp, 1'b1, 8'hA5);
      send_request(OP_UNPKBW, 64'h0, ramp, 1'b0, 8'h00);
      send_request(OP_PKWB, 64'h0, '1, 1'b0, 8'h00);
      send_request(OP_UNPKBW, '1, '1, 1'b1, 8'h00);
      idle_cycles($urandom_range(1, 5));

      // random requests in bursts with gaps, some stretches without gaps
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 40);
         for (k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
            send_random_request();
            sent++;
            if (sent == RANDOM_REQUESTS / 2) wait_drained();
         end
         if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 8));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && dest_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/pma_pkg.sv
src/packed_media_alu_unit.sv
test/packed_media_alu_checker.sv
test/tb_packed_media_alu_unit.sv
